// ===== design/dkrj_pkg.sv =====
package dkrj_pkg;

  localparam int unsigned DefMaxEntries = 64;
  localparam int unsigned DefKeyBits    = 64;

  // Widest key and slot index the table supports; narrower settings leave upper bits at zero.
  localparam int unsigned KeyMaxW  = 64;
  localparam int unsigned SlotMaxW = 10;
  localparam int unsigned UsedW    = SlotMaxW + 1;

  localparam int unsigned RingW = 7;
  localparam logic [RingW-1:0] RingReset = 7'd64;

  localparam logic CmdQuery  = 1'b0;
  localparam logic CmdRecord = 1'b1;

  localparam logic StatusOk     = 1'b0;
  localparam logic StatusBadArg = 1'b1;

  // Search token that walks the chain, one cell per cycle.
  typedef struct packed {
    logic                live;
    logic                rec;
    logic [KeyMaxW-1:0]  key;
    logic [SlotMaxW-1:0] slot;
    logic                hit;
    logic                slot_valid;
  } probe_t;

  // Broadcast write of a new key into one cell.
  typedef struct packed {
    logic                en;
    logic [SlotMaxW-1:0] slot;
    logic [KeyMaxW-1:0]  key;
  } wr_t;

endpackage

// ===== design/dkrj_cell.sv =====
module dkrj_cell
  import dkrj_pkg::*;
#(
  parameter int unsigned CellIdx = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [UsedW-1:0] used_i,
  input  probe_t           probe_i,
  input  wr_t              wr_i,
  output probe_t           probe_o
);

  logic               valid_q;
  logic [KeyMaxW-1:0] key_q;
  probe_t             probe_d, probe_q;
  logic               in_use;
  logic               mine;

  assign in_use = UsedW'(CellIdx) < used_i;
  assign mine   = probe_i.slot == SlotMaxW'(CellIdx);

  always_comb begin
    probe_d = probe_i;
    if (in_use && valid_q && (key_q == probe_i.key)) begin
      probe_d.hit = 1'b1;
    end
    // The cell at the write pointer reports whether it already holds an entry.
    if (mine) begin
      probe_d.slot_valid = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
      valid_q <= 1'b0;
    end else begin
      probe_q <= probe_d;
      if (wr_i.en && (wr_i.slot == SlotMaxW'(CellIdx))) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.slot == SlotMaxW'(CellIdx))) begin
      key_q <= wr_i.key;
    end
  end

  assign probe_o = probe_q;

endmodule

// ===== design/dedup_key_ring_journal_core.sv =====
// Duplicate-detection key table with first-in first-out replacement.
// Input channel s_axis: tuser carries the command (query or record), tdata the key word
// and a timestamp. Output channel m_axis: one result transaction per input transaction,
// with status, hit flag and the number of valid entries after the item.
// The table size in use is set through cfg_we_i / cfg_wdata_i; the user must write it only
// while the block is idle, as the block itself does not enforce this. The table is a row of
// MAX_ENTRIES cells. An accepted item walks the row one cell per cycle, collecting the hit
// flag and the occupancy of the write slot; at the end of the row the result is formed and,
// for a record of a new nonzero key, the key is written into its slot in the same cycle.
// One item at a time is in the row or waiting at its end: a new item is taken only after
// the previous one has formed its result. Reset clears all valid bits, the write pointer and
// the entry count, and sets the table size to 64. A stalled receiver holds the result in the
// output register; the next item may still be accepted and runs down the row, then waits at
// the end of the row until the output register is free.
module dedup_key_ring_journal_core
  import dkrj_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = DefMaxEntries,
  parameter int unsigned KEY_BITS    = DefKeyBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [RingW-1:0] cfg_wdata_i,    // ring_size
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [127:0]     s_axis_tdata,   // lookup_key[63:0], time_stamp[127:64]
  input  logic [0:0]       s_axis_tuser,   // cmd[0]
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata    // status[0], hit[1], entry_total[8:2], zero[15:9]
);

  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam logic [KeyMaxW-1:0] KeyMask = {KeyMaxW{1'b1}} >> (KeyMaxW - KEY_BITS);

  logic [RingW-1:0] ring_q;
  logic [IdxW-1:0]  widx_q;
  logic [CntW-1:0]  count_q;
  logic             busy_q;
  probe_t           pend_q;
  logic             pend_vld_q;
  logic             out_vld_q;
  logic             status_q, hit_q;
  logic [RingW-1:0] total_q;

  logic [UsedW-1:0] used;
  logic [UsedW-1:0] widx_ext;
  logic [UsedW-1:0] slot_next;
  logic             s_fire;
  logic             commit;
  logic             key_zero;
  logic             do_write;
  logic [CntW-1:0]  count_d;
  probe_t           head;
  wr_t              wr;
  probe_t           link [MAX_ENTRIES+1];

  always_comb begin
    if (ring_q == '0) begin
      used = UsedW'(1);
    end else if (UsedW'(ring_q) > UsedW'(MAX_ENTRIES)) begin
      used = UsedW'(MAX_ENTRIES);
    end else begin
      used = UsedW'(ring_q);
    end
  end

  assign s_axis_tready = !busy_q;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign widx_ext      = UsedW'(widx_q);

  always_comb begin
    head            = '0;
    head.live       = s_fire;
    head.rec        = s_axis_tuser[0] == CmdRecord;
    head.key        = s_axis_tdata[KeyMaxW-1:0] & KeyMask;
    // A pointer left beyond a lowered ring size writes slot zero.
    head.slot       = (widx_ext < used) ? SlotMaxW'(widx_q) : '0;
  end

  assign link[0] = head;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    dkrj_cell #(
      .CellIdx(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .used_i (used),
      .probe_i(link[i]),
      .wr_i   (wr),
      .probe_o(link[i+1])
    );
  end

  assign commit    = pend_vld_q && (!out_vld_q || m_axis_tready);
  assign key_zero  = pend_q.key == '0;
  assign do_write  = pend_q.rec && !key_zero && !pend_q.hit;
  assign slot_next = UsedW'(pend_q.slot) + UsedW'(1);
  assign count_d   = (do_write && !pend_q.slot_valid) ? count_q + CntW'(1) : count_q;

  always_comb begin
    wr.en   = commit && do_write;
    wr.slot = pend_q.slot;
    wr.key  = pend_q.key;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q     <= RingReset;
      widx_q     <= '0;
      count_q    <= '0;
      busy_q     <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ring_q <= cfg_wdata_i;
      end
      if (s_fire) begin
        busy_q <= 1'b1;
      end else if (commit) begin
        busy_q <= 1'b0;
      end
      if (link[MAX_ENTRIES].live) begin
        pend_vld_q <= 1'b1;
      end else if (commit) begin
        pend_vld_q <= 1'b0;
      end
      if (commit) begin
        out_vld_q <= 1'b1;
        count_q   <= count_d;
        if (do_write) begin
          widx_q <= (slot_next >= used) ? '0 : IdxW'(slot_next);
        end
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (link[MAX_ENTRIES].live) begin
      pend_q <= link[MAX_ENTRIES];
    end
    if (commit) begin
      status_q <= (key_zero && pend_q.rec) ? StatusBadArg : StatusOk;
      hit_q    <= !key_zero && pend_q.hit;
      total_q  <= RingW'(count_d);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, total_q, hit_q, status_q};

endmodule

// ===== design/dkrj_checker.sv =====
module dkrj_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // A result waiting for the receiver must not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // An invalid-argument result never reports a hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("hit reported with invalid-argument status");

  // Only one item is in flight: the input closes right after a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted a second item while busy");

  // The search passes through the whole cell row, so no result can appear in the cycle after acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

endmodule

bind dedup_key_ring_journal_core dkrj_checker u_dkrj_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
